@@ hw/rtl/sbk_pkg.sv @@
// Shared constants, types and the key table for the scan byte to BIOS key decoder.
`timescale 1ns / 1ps

package sbk_pkg;

  localparam int unsigned ScanW = 8;
  localparam int unsigned CodeW = 7;
  localparam int unsigned KeyW  = 16;
  localparam int unsigned ColW  = 2;

  localparam logic [ScanW-1:0] SCAN_NONE   = 8'h00;
  localparam logic [ScanW-1:0] SCAN_PREFIX = 8'hE0;

  localparam logic [CodeW-1:0] CODE_CTRL   = 7'h1D;
  localparam logic [CodeW-1:0] CODE_ALT    = 7'h38;
  localparam logic [CodeW-1:0] CODE_LSHIFT = 7'h2A;
  localparam logic [CodeW-1:0] CODE_RSHIFT = 7'h36;
  localparam logic [CodeW-1:0] CODE_CAPS   = 7'h3A;

  localparam logic [KeyW-1:0] NO_KEY = 16'hFFFF;

  localparam logic [ColW-1:0] COL_NORMAL = 2'd0;
  localparam logic [ColW-1:0] COL_SHIFT  = 2'd1;
  localparam logic [ColW-1:0] COL_CTRL   = 2'd2;
  localparam logic [ColW-1:0] COL_ALT    = 2'd3;

  typedef logic [0:3][KeyW-1:0] key_row_t;

  typedef struct packed {
    logic            hit;
    logic [KeyW-1:0] word;
  } sbk_res_t;

  // one row per make code: normal, shifted, ctrl, alt
  function automatic key_row_t key_row(input logic [CodeW-1:0] code);
    key_row_t row;
    row = {NO_KEY, NO_KEY, NO_KEY, NO_KEY};
    unique case (code)
      7'h01: row = {16'h011B, 16'h011B, 16'h011B, 16'h0100};
      7'h02: row = {16'h0231, 16'h0221, 16'h7800, 16'hFFFF};
      7'h03: row = {16'h0332, 16'h0340, 16'h0300, 16'h7900};
      7'h04: row = {16'h0433, 16'h0423, 16'h7A00, 16'hFFFF};
      7'h05: row = {16'h0534, 16'h0524, 16'h7B00, 16'hFFFF};
      7'h06: row = {16'h0635, 16'h0625, 16'h7C00, 16'hFFFF};
      7'h07: row = {16'h0736, 16'h075E, 16'h071E, 16'h7D00};
      7'h08: row = {16'h0837, 16'h0826, 16'h7E00, 16'hFFFF};
      7'h09: row = {16'h0938, 16'h092A, 16'h7F00, 16'hFFFF};
      7'h0A: row = {16'h0A39, 16'h0A28, 16'h8000, 16'hFFFF};
      7'h0B: row = {16'h0B30, 16'h0B29, 16'h8100, 16'hFFFF};
      7'h0C: row = {16'h0C2D, 16'h0C5F, 16'h0C1F, 16'h8200};
      7'h0D: row = {16'h0D3D, 16'h0D2B, 16'h8300, 16'hFFFF};
      7'h0E: row = {16'h0E08, 16'h0E08, 16'h0E7F, 16'h0E00};
      7'h0F: row = {16'h0F09, 16'h0F00, 16'h9400, 16'hA500};
      7'h10: row = {16'h1071, 16'h1051, 16'h1011, 16'h1000};
      7'h11: row = {16'h1177, 16'h1157, 16'h1117, 16'h1100};
      7'h12: row = {16'h1265, 16'h1245, 16'h1205, 16'h1200};
      7'h13: row = {16'h1372, 16'h1352, 16'h1312, 16'h1300};
      7'h14: row = {16'h1474, 16'h1454, 16'h1414, 16'h1400};
      7'h15: row = {16'h1579, 16'h1559, 16'h1519, 16'h1500};
      7'h16: row = {16'h1675, 16'h1655, 16'h1615, 16'h1600};
      7'h17: row = {16'h1769, 16'h1749, 16'h1709, 16'h1700};
      7'h18: row = {16'h186F, 16'h184F, 16'h180F, 16'h1800};
      7'h19: row = {16'h1970, 16'h1950, 16'h1910, 16'h1900};
      7'h1A: row = {16'h1A5B, 16'h1A7B, 16'h1A1B, 16'h1A00};
      7'h1B: row = {16'h1B5D, 16'h1B7D, 16'h1B1D, 16'h1B00};
      7'h1C: row = {16'h1C0D, 16'h1C0D, 16'h1C0A, 16'hA600};
      7'h1E: row = {16'h1E61, 16'h1E41, 16'h1E01, 16'h1E00};
      7'h1F: row = {16'h1F73, 16'h1F53, 16'h1F13, 16'h1F00};
      7'h20: row = {16'h2064, 16'h2044, 16'h2004, 16'h2000};
      7'h21: row = {16'h2166, 16'h2146, 16'h2106, 16'h2100};
      7'h22: row = {16'h2267, 16'h2247, 16'h2207, 16'h2200};
      7'h23: row = {16'h2368, 16'h2348, 16'h2308, 16'h2300};
      7'h24: row = {16'h246A, 16'h244A, 16'h240A, 16'h2400};
      7'h25: row = {16'h256B, 16'h254B, 16'h250B, 16'h2500};
      7'h26: row = {16'h266C, 16'h264C, 16'h260C, 16'h2600};
      7'h27: row = {16'h273B, 16'h273A, 16'h2700, 16'hFFFF};
      7'h28: row = {16'h2827, 16'h2822, 16'hFFFF, 16'hFFFF};
      7'h29: row = {16'h2960, 16'h297E, 16'hFFFF, 16'hFFFF};
      7'h2B: row = {16'h2B5C, 16'h2B7C, 16'h2B1C, 16'h2600};
      7'h2C: row = {16'h2C7A, 16'h2C5A, 16'h2C1A, 16'h2C00};
      7'h2D: row = {16'h2D78, 16'h2D58, 16'h2D18, 16'h2D00};
      7'h2E: row = {16'h2E63, 16'h2E43, 16'h2E03, 16'h2E00};
      7'h2F: row = {16'h2F76, 16'h2F56, 16'h2F16, 16'h2F00};
      7'h30: row = {16'h3062, 16'h3042, 16'h3002, 16'h3000};
      7'h31: row = {16'h316E, 16'h314E, 16'h310E, 16'h3100};
      7'h32: row = {16'h326D, 16'h324D, 16'h320D, 16'h3200};
      7'h33: row = {16'h332C, 16'h333C, 16'hFFFF, 16'hFFFF};
      7'h34: row = {16'h342E, 16'h343E, 16'hFFFF, 16'hFFFF};
      7'h35: row = {16'h352F, 16'h353F, 16'hFFFF, 16'hFFFF};
      7'h37: row = {16'h372A, 16'h9600, 16'h3700, 16'hFFFF};
      7'h39: row = {16'h3920, 16'h3920, 16'h3920, 16'h3920};
      7'h3B: row = {16'h3B00, 16'h5400, 16'h5E00, 16'h6800};
      7'h3C: row = {16'h3C00, 16'h5500, 16'h5F00, 16'h6900};
      7'h3D: row = {16'h3D00, 16'h5600, 16'h6000, 16'h6A00};
      7'h3E: row = {16'h3E00, 16'h5700, 16'h6100, 16'h6B00};
      7'h3F: row = {16'h3F00, 16'h5800, 16'h6200, 16'h6C00};
      7'h40: row = {16'h4000, 16'h5900, 16'h6300, 16'h6D00};
      7'h41: row = {16'h4100, 16'h5A00, 16'h6400, 16'h6E00};
      7'h42: row = {16'h4200, 16'h5B00, 16'h6500, 16'h6F00};
      7'h43: row = {16'h4300, 16'h5C00, 16'h6600, 16'h7000};
      7'h44: row = {16'h4400, 16'h5D00, 16'h6700, 16'h7100};
      7'h47: row = {16'h4700, 16'h4737, 16'h7700, 16'h9700};
      7'h48: row = {16'h4800, 16'h4838, 16'h8D00, 16'h9800};
      7'h49: row = {16'h4900, 16'h4939, 16'h8400, 16'h9900};
      7'h4A: row = {16'h4A2D, 16'h4A2D, 16'h8E00, 16'h4A00};
      7'h4B: row = {16'h4B00, 16'h4B34, 16'h7300, 16'h9B00};
      7'h4D: row = {16'h4D00, 16'h4D36, 16'h7400, 16'h9D00};
      7'h4E: row = {16'h4E2B, 16'h4E2B, 16'h4E00, 16'hFFFF};
      7'h4F: row = {16'h4F00, 16'h4F31, 16'h7500, 16'h9F00};
      7'h50: row = {16'h5000, 16'h5032, 16'h9100, 16'hA000};
      7'h51: row = {16'h5100, 16'h5133, 16'h7600, 16'hA100};
      7'h52: row = {16'h5200, 16'h5230, 16'h9200, 16'hA200};
      7'h53: row = {16'h5300, 16'h532E, 16'h9300, 16'hA300};
      default: row = {NO_KEY, NO_KEY, NO_KEY, NO_KEY};
    endcase
    return row;
  endfunction

endpackage

@@ hw/rtl/scancode_to_bios_keycode.sv @@
// Top level of the set-1 scan byte to BIOS key word decoder.
//
// Input channel: in_valid_i / in_stall_o carry one raw scan byte per beat.
// Output channel: out_valid_o / out_stall_i carry one 16-bit BIOS key word.
// A beat moves when valid is high and stall is low at a rising edge.
// Zero bytes, prefix bytes, modifier codes, break codes, extended keys and
// empty table entries produce no output beat; other make codes produce one.
// A key word passes through the input register, then the result register behind
// the table lookup, before it is offered on the output.
// Throughput: one byte per cycle while the receiver does not stall, set by
// the single table lookup between the two registers; the next byte is taken
// while a result waits. When the receiver stalls, the result register holds
// its word; a byte that yields no word still passes, and one that yields a
// word waits in the input register, which then raises in_stall_o.
// Reset clears all modifier flags, the extended flag and both valid bits.
`timescale 1ns / 1ps

module scancode_to_bios_keycode
  import sbk_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ScanW-1:0] scan_byte_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [KeyW-1:0]  key_code_o
);

  logic             beat_valid;
  logic [ScanW-1:0] beat_scan;
  logic             adv;
  sbk_res_t         res;

  assign adv = beat_valid && (!res.hit || !out_valid_o || !out_stall_i);

  sbk_in_stage u_in (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .scan_byte_i (scan_byte_i),
    .in_stall_o  (in_stall_o),
    .adv_i       (adv),
    .valid_o     (beat_valid),
    .scan_o      (beat_scan)
  );

  sbk_decoder u_dec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (beat_valid),
    .adv_i   (adv),
    .scan_i  (beat_scan),
    .res_o   (res)
  );

  sbk_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv && res.hit),
    .word_i      (res.word),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .key_code_o  (key_code_o)
  );

endmodule

@@ hw/rtl/sbk_in_stage.sv @@
// Input register for scan byte beats.
`timescale 1ns / 1ps

module sbk_in_stage
  import sbk_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ScanW-1:0] scan_byte_i,
  output logic             in_stall_o,
  input  logic             adv_i,
  output logic             valid_o,
  output logic [ScanW-1:0] scan_o
);

  logic             valid_q, valid_d;
  logic [ScanW-1:0] scan_q;
  logic             take;

  assign in_stall_o = valid_q && !adv_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      scan_q <= scan_byte_i;
    end
  end

  assign valid_o = valid_q;
  assign scan_o  = scan_q;

endmodule

@@ hw/rtl/sbk_decoder.sv @@
// Modifier tracking and key table lookup for one scan byte.
`timescale 1ns / 1ps

module sbk_decoder
  import sbk_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic             adv_i,
  input  logic [ScanW-1:0] scan_i,
  output sbk_res_t         res_o
);

  logic ext_q, ext_d;
  logic ctrl_q, ctrl_d;
  logic shift_q, shift_d;
  logic alt_q, alt_d;
  logic caps_q, caps_d;

  logic [CodeW-1:0] code;
  logic             brk;
  logic             is_none, is_prefix;
  logic             is_ctrl, is_alt, is_shift, is_caps, is_mod;
  logic [ColW-1:0]  col;
  key_row_t         row;
  logic [KeyW-1:0]  word;

  assign code      = scan_i[CodeW-1:0];
  assign brk       = scan_i[ScanW-1];
  assign is_none   = (scan_i == SCAN_NONE);
  assign is_prefix = (scan_i == SCAN_PREFIX);
  assign is_ctrl   = (code == CODE_CTRL);
  assign is_alt    = (code == CODE_ALT);
  assign is_shift  = !ext_q && ((code == CODE_LSHIFT) || (code == CODE_RSHIFT));
  assign is_caps   = !ext_q && (code == CODE_CAPS);
  assign is_mod    = is_ctrl || is_alt || is_shift || is_caps;

  always_comb begin
    if (caps_q != shift_q) begin
      col = COL_SHIFT;
    end else if (ctrl_q) begin
      col = COL_CTRL;
    end else if (alt_q) begin
      col = COL_ALT;
    end else begin
      col = COL_NORMAL;
    end
  end

  assign row  = key_row(code);
  assign word = row[col];

  assign res_o.hit  = valid_i && !is_none && !is_prefix && !is_mod && !brk && !ext_q &&
                      (word != NO_KEY);
  assign res_o.word = word;

  always_comb begin
    ext_d   = ext_q;
    ctrl_d  = ctrl_q;
    shift_d = shift_q;
    alt_d   = alt_q;
    caps_d  = caps_q;
    if (adv_i && !is_none) begin
      if (is_prefix) begin
        ext_d = 1'b1;
      end else begin
        ext_d = 1'b0;
        if (is_ctrl) begin
          ctrl_d = !brk;
        end else if (is_alt) begin
          alt_d = !brk;
        end else if (is_shift) begin
          shift_d = !brk;
        end else if (is_caps) begin
          caps_d = !brk;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q   <= 1'b0;
      ctrl_q  <= 1'b0;
      shift_q <= 1'b0;
      alt_q   <= 1'b0;
      caps_q  <= 1'b0;
    end else begin
      ext_q   <= ext_d;
      ctrl_q  <= ctrl_d;
      shift_q <= shift_d;
      alt_q   <= alt_d;
      caps_q  <= caps_d;
    end
  end

`ifndef ASSERT_OFF
  a_hit_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.hit |-> (res_o.word != NO_KEY))
    else $error("decoder hit on an empty table entry");

  a_prefix_sets_ext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && is_prefix) |=> ext_q)
    else $error("prefix beat did not set extended flag");

  a_zero_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && is_none) |=> ($stable(ext_q) && $stable(ctrl_q) && $stable(shift_q) &&
                            $stable(alt_q) && $stable(caps_q)))
    else $error("zero beat changed modifier state");

  a_no_hit_on_break: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.hit |-> (!brk && !ext_q))
    else $error("break or extended beat produced a key");
`endif

endmodule

@@ hw/rtl/sbk_out_stage.sv @@
// Result register for BIOS key word beats.
`timescale 1ns / 1ps

module sbk_out_stage
  import sbk_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic [KeyW-1:0] word_i,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output logic [KeyW-1:0] key_code_o
);

  logic            valid_q, valid_d;
  logic [KeyW-1:0] key_q;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      key_q <= word_i;
    end
  end

  assign out_valid_o = valid_q;
  assign key_code_o  = key_q;

endmodule
